>>> sv/mjge_pkg.sv
// ----------------------------------------------------------------------------
// mjge_pkg
// Shared types and constants for the maze junction graph extractor.
// ----------------------------------------------------------------------------
package mjge_pkg;

    // width of reported coordinates and distances
    localparam int unsigned COORD_W = 10;

    // width of the image_width configuration register
    localparam int unsigned IMG_W_W = 11;

    // register index carried by paddr[2]
    localparam logic REG_IMAGE_WIDTH = 1'b0;

    // reset value of image_width
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;

    // one line buffer entry per column
    typedef struct packed {
        logic               above;   // pixel two rows back (row above the judged row)
        logic               center;  // pixel of the judged row
        logic               cvalid;  // column link open since the last node
        logic [COORD_W-1:0] crow;    // row of the last node in this column
    } mjge_entry_t;

    // result transaction payload
    typedef struct packed {
        logic [COORD_W-1:0] node_col;
        logic [COORD_W-1:0] node_row;
        logic               is_head;
        logic               row_link_valid;
        logic [COORD_W-1:0] row_link_col;
        logic [COORD_W-1:0] row_distance;
        logic               col_link_valid;
        logic [COORD_W-1:0] col_link_row;
        logic [COORD_W-1:0] col_distance;
    } mjge_result_t;

endpackage

>>> sv/maze_junction_graph_extract_core.sv
// ----------------------------------------------------------------------------
// maze_junction_graph_extract_core
// Streams a binary maze raster and emits junction nodes with row/column links.
// ----------------------------------------------------------------------------
// Pixels enter one per clock in row order while s_ready is high. Each pixel is
// judged when the pixel below it arrives; a node transaction then leaves via
// the judge stage and output registers. One pixel per cycle holds unless a
// node waits on a stalled output: each pixel costs one read and one write of
// the single line buffer memory, holding both pixel rows and the per-column
// link state. After reset a clearing pass writes all MAX_WIDTH entries, one per
// cycle, with s_ready low. Append one all-wall row after the last image row.
module maze_junction_graph_extract_core #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // pixel input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_pixel,
    // node output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mjge_pkg::COORD_W-1:0] m_node_col,
    output logic [mjge_pkg::COORD_W-1:0] m_node_row,
    output logic                         m_is_head,
    output logic                         m_row_link_valid,
    output logic [mjge_pkg::COORD_W-1:0] m_row_link_col,
    output logic [mjge_pkg::COORD_W-1:0] m_row_distance,
    output logic                         m_col_link_valid,
    output logic [mjge_pkg::COORD_W-1:0] m_col_link_row,
    output logic [mjge_pkg::COORD_W-1:0] m_col_distance
);

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WW = (CW + 1 > mjge_pkg::IMG_W_W) ? CW + 1 : mjge_pkg::IMG_W_W;
    localparam int unsigned KW = mjge_pkg::COORD_W;

    // configuration register
    logic [mjge_pkg::IMG_W_W-1:0] image_width_reg;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == mjge_pkg::REG_IMAGE_WIDTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= mjge_pkg::IMAGE_WIDTH_RESET;
        end else if (cfg_write) begin
            image_width_reg <= pwdata[mjge_pkg::IMG_W_W-1:0];
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        if (paddr[2] == mjge_pkg::REG_IMAGE_WIDTH) begin
            prdata = {{(32 - mjge_pkg::IMG_W_W){1'b0}}, image_width_reg};
        end
    end

    // usable width, limited to 1..MAX_WIDTH
    logic [WW-1:0] width_raw;
    logic [WW-1:0] width_eff;

    assign width_raw = WW'(image_width_reg);

    always_comb begin
        width_eff = width_raw;
        if (width_raw == '0) begin
            width_eff = WW'(1);
        end else if (width_raw > WW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end
    end

    // clearing pass after reset
    logic          clr_active_reg;
    logic [CW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == CW'(MAX_WIDTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // input side: column/row counters, next read address
    logic          in_accept;
    logic [CW-1:0] col_counter_reg;
    logic [CW-1:0] col_counter_next;
    logic [KW-1:0] row_counter_reg;
    logic [KW-1:0] row_counter_next;
    logic [WW-1:0] col_plus1;
    logic          col_wrap;

    assign in_accept = s_valid && s_ready;
    assign col_plus1 = WW'(col_counter_reg) + WW'(1);
    assign col_wrap  = (col_plus1 >= width_eff);

    always_comb begin
        col_counter_next = col_counter_reg;
        row_counter_next = row_counter_reg;
        if (in_accept) begin
            if (col_wrap) begin
                col_counter_next = '0;
                row_counter_next = row_counter_reg + KW'(1);
            end else begin
                col_counter_next = col_plus1[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_counter_reg <= '0;
            row_counter_reg <= '0;
        end else begin
            col_counter_reg <= col_counter_next;
            row_counter_reg <= row_counter_next;
        end
    end

    // judge stage registers
    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_pix_reg;
    logic          s1_wrap_reg;
    logic [KW-1:0] s1_row_reg;
    logic          s1_go;
    logic          s1_fire;
    logic          s1_node;

    assign s1_go   = !s1_valid_reg || !s1_node || !m_valid || m_ready;
    assign s1_fire = s1_valid_reg && s1_go;
    assign s_ready = !clr_active_reg && s1_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_col_reg  <= col_counter_reg;
            s1_pix_reg  <= s_pixel;
            s1_wrap_reg <= col_wrap;
            s1_row_reg  <= row_counter_reg - KW'(1);
        end
    end

    // line buffer memory: one write, one registered read
    mjge_pkg::mjge_entry_t lbuf_mem [MAX_WIDTH];
    mjge_pkg::mjge_entry_t mem_q_reg;
    mjge_pkg::mjge_entry_t mem_wdata;
    mjge_pkg::mjge_entry_t upd_entry;
    logic [CW-1:0]         mem_waddr;
    logic                  mem_we;
    logic                  s1_we;

    assign s1_we     = s1_fire;
    assign mem_we    = clr_active_reg || s1_we;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : s1_col_reg;
    assign mem_wdata = clr_active_reg ? '0 : upd_entry;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lbuf_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            mem_q_reg <= lbuf_mem[col_counter_next];
        end
    end

    // forwarding around the memory for writes that hit the held read address
    logic                  fwd_hit_reg;
    mjge_pkg::mjge_entry_t fwd_data_reg;
    mjge_pkg::mjge_entry_t rd_entry;

    assign rd_entry = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg  <= 1'b1;
            fwd_data_reg <= '0;
        end else if (clr_active_reg) begin
            fwd_hit_reg  <= 1'b1;
            fwd_data_reg <= '0;
        end else if (in_accept) begin
            fwd_hit_reg  <= s1_we && (s1_col_reg == col_counter_next);
            fwd_data_reg <= upd_entry;
        end else if (s1_we && (s1_col_reg == col_counter_reg)) begin
            fwd_hit_reg  <= 1'b1;
            fwd_data_reg <= upd_entry;
        end
    end

    // entry of the column under judgement, captured on accept
    mjge_pkg::mjge_entry_t cur_reg;
    mjge_pkg::mjge_entry_t cur_next;

    always_comb begin
        cur_next = cur_reg;
        if (in_accept) begin
            cur_next = (s1_we && (s1_col_reg == col_counter_reg)) ? upd_entry : rd_entry;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    // neighbourhood and node decision
    logic          last_mid_reg;
    logic          row_valid_reg;
    logic [KW-1:0] row_last_col_reg;
    logic          head_seen_reg;
    logic          nb_top;
    logic          nb_mid;
    logic          nb_bot;
    logic          nb_left;
    logic          nb_right;
    logic          col_first;
    logic          row_link_ok;
    logic [KW-1:0] s1_col_k;

    assign col_first   = (s1_col_reg == '0);
    assign nb_top      = cur_reg.above;
    assign nb_mid      = cur_reg.center;
    assign nb_bot      = s1_pix_reg;
    assign nb_left     = !col_first && last_mid_reg;
    assign nb_right    = !s1_wrap_reg && rd_entry.center;
    assign row_link_ok = !col_first && row_valid_reg;
    assign s1_col_k    = KW'(s1_col_reg);
    assign s1_node     = nb_mid && ((nb_left != nb_right) || (nb_top != nb_bot) ||
                                    (nb_top && nb_bot && nb_left && nb_right));

    // entry written back for the judged column
    always_comb begin
        upd_entry.above  = nb_mid;
        upd_entry.center = nb_bot;
        upd_entry.cvalid = nb_mid && (s1_node || cur_reg.cvalid);
        upd_entry.crow   = s1_node ? s1_row_reg : cur_reg.crow;
    end

    // running row link and head flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= 1'b0;
            head_seen_reg <= 1'b0;
        end else if (s1_fire) begin
            row_valid_reg <= nb_mid && (s1_node || row_link_ok);
            head_seen_reg <= head_seen_reg || s1_node;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            last_mid_reg <= nb_mid;
            if (s1_node) begin
                row_last_col_reg <= s1_col_k;
            end
        end
    end

    // result assembly
    mjge_pkg::mjge_result_t res_next;
    mjge_pkg::mjge_result_t res_reg;
    logic                   m_valid_reg;

    always_comb begin
        res_next                = '0;
        res_next.node_col       = s1_col_k;
        res_next.node_row       = s1_row_reg;
        res_next.is_head        = !head_seen_reg;
        res_next.row_link_valid = row_link_ok;
        if (row_link_ok) begin
            res_next.row_link_col = row_last_col_reg;
            res_next.row_distance = s1_col_k - row_last_col_reg;
        end
        res_next.col_link_valid = cur_reg.cvalid;
        if (cur_reg.cvalid) begin
            res_next.col_link_row = cur_reg.crow;
            res_next.col_distance = s1_row_reg - cur_reg.crow;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_node) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_node) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_node_col       = res_reg.node_col;
    assign m_node_row       = res_reg.node_row;
    assign m_is_head        = res_reg.is_head;
    assign m_row_link_valid = res_reg.row_link_valid;
    assign m_row_link_col   = res_reg.row_link_col;
    assign m_row_distance   = res_reg.row_distance;
    assign m_col_link_valid = res_reg.col_link_valid;
    assign m_col_link_row   = res_reg.col_link_row;
    assign m_col_distance   = res_reg.col_distance;

endmodule

>>> sv/mjge_checker.sv
// ----------------------------------------------------------------------------
// mjge_checker
// Port-level checks for the maze junction graph extractor, bound to the core.
// ----------------------------------------------------------------------------
module mjge_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_node_col,
    input logic [9:0] m_node_row,
    input logic       m_row_link_valid,
    input logic [9:0] m_row_link_col,
    input logic [9:0] m_row_distance,
    input logic       m_col_link_valid,
    input logic [9:0] m_col_link_row,
    input logic [9:0] m_col_distance
);

    // stalled result transaction holds its node column and row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_node_col) && $stable(m_node_row))
        else $error("stalled result changed");

    // reset empties the output and starts the clearing pass
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output or input active after reset");

    // row link distance matches the coordinates, zero without a link
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_row_link_valid ? (m_row_distance == 10'(m_node_col - m_row_link_col))
                                      : (m_row_link_col == 10'd0 && m_row_distance == 10'd0)))
        else $error("row link fields inconsistent");

    // column link distance matches the coordinates, zero without a link
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_col_link_valid ? (m_col_distance == 10'(m_node_row - m_col_link_row))
                                      : (m_col_link_row == 10'd0 && m_col_distance == 10'd0)))
        else $error("column link fields inconsistent");

endmodule

bind maze_junction_graph_extract_core mjge_checker u_mjge_checker (.*);

>>> dv/maze_junction_graph_extract_core_test.sv
// ----------------------------------------------------------------------------
// maze_junction_graph_extract_core_test
// Self-checking bench for the maze junction extractor: streams maze rasters of
// many widths through the pixel port, predicts every junction node with its
// row and column links, and checks each node transaction field by field while
// both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maze_junction_graph_extract_core_test;

    localparam int unsigned MAX_W           = 1024;
    localparam int unsigned HOLD_CYCLES     = 1500;
    localparam int unsigned DRAIN_CYCLES    = 16;
    // covers the clearing pass after reset and the long output hold-off
    localparam int unsigned WATCHDOG_CYCLES = 10000;

    // junction predictor and store of expected node transactions
    class junction_tracker;
        bit                                above    [MAX_W];
        bit                                center   [MAX_W];
        bit                                col_open [MAX_W];
        bit [10:0]                         col_row  [MAX_W];
        bit                                row_open;
        bit [mjge_pkg::COORD_W-1:0]        row_col;
        int unsigned                       col_cnt;
        bit [10:0]                         row_cnt;
        bit                                head_seen;
        bit [mjge_pkg::IMG_W_W-1:0]        width_reg;
        mjge_pkg::mjge_result_t            pending_nodes [$];
        int unsigned                       errors;
        int unsigned                       nodes_checked;

        function new();
            foreach (above[i]) begin
                above[i]    = 1'b0;
                center[i]   = 1'b0;
                col_open[i] = 1'b0;
                col_row[i]  = '0;
            end
            row_open  = 1'b0;
            row_col   = '0;
            col_cnt   = 0;
            row_cnt   = '0;
            head_seen = 1'b0;
            width_reg = mjge_pkg::IMAGE_WIDTH_RESET;
            errors    = 0;
            nodes_checked = 0;
        endfunction

        function void set_width(bit [mjge_pkg::IMG_W_W-1:0] value);
            width_reg = value;
        endfunction

        // judge the pixel one row up, now that the pixel below it is known
        function void take_pixel(bit bot);
            int unsigned            w;
            int unsigned            c;
            bit [10:0]              judged;
            bit                     top;
            bit                     mid;
            bit                     left;
            bit                     right;
            mjge_pkg::mjge_result_t r;
            w = (width_reg == 0) ? 1 : width_reg;
            if (w > MAX_W) w = MAX_W;
            c = col_cnt;
            if (c >= MAX_W) c = MAX_W - 1;
            judged = row_cnt - 11'd1;
            if (c == 0) row_open = 1'b0;

            top   = above[c];
            mid   = center[c];
            // above[c-1] already holds the old center pixel of the left column
            left  = (c > 0) ? above[c - 1] : 1'b0;
            right = (c + 1 < w) ? center[c + 1] : 1'b0;
            above[c]  = mid;
            center[c] = bot;

            if (!mid) begin
                row_open    = 1'b0;
                col_open[c] = 1'b0;
            end else if ((left != right) || (top != bot) || (top && bot && left && right)) begin
                r = '0;
                r.node_col = c[mjge_pkg::COORD_W-1:0];
                r.node_row = judged[mjge_pkg::COORD_W-1:0];
                r.is_head  = !head_seen;
                if (row_open) begin
                    r.row_link_valid = 1'b1;
                    r.row_link_col   = row_col;
                    r.row_distance   = c[mjge_pkg::COORD_W-1:0] - row_col;
                end
                if (col_open[c]) begin
                    r.col_link_valid = 1'b1;
                    r.col_link_row   = col_row[c][mjge_pkg::COORD_W-1:0];
                    r.col_distance   = judged[mjge_pkg::COORD_W-1:0] -
                                       col_row[c][mjge_pkg::COORD_W-1:0];
                end
                head_seen   = 1'b1;
                row_open    = 1'b1;
                row_col     = c[mjge_pkg::COORD_W-1:0];
                col_open[c] = 1'b1;
                col_row[c]  = judged;
                pending_nodes.insert(pending_nodes.size(), r);
            end

            if (c + 1 >= w) begin
                col_cnt = 0;
                row_cnt = row_cnt + 11'd1;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void compare(string name, logic [mjge_pkg::COORD_W-1:0] want,
                              logic [mjge_pkg::COORD_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_node(mjge_pkg::mjge_result_t got);
            mjge_pkg::mjge_result_t want;
            if (pending_nodes.size() == 0) begin
                $error("unexpected node at col %0d row %0d", got.node_col, got.node_row);
                errors++;
                return;
            end
            want = pending_nodes.pop_front();
            nodes_checked++;
            compare("node_col",       want.node_col,       got.node_col);
            compare("node_row",       want.node_row,       got.node_row);
            compare("is_head",        want.is_head,        got.is_head);
            compare("row_link_valid", want.row_link_valid, got.row_link_valid);
            compare("row_link_col",   want.row_link_col,   got.row_link_col);
            compare("row_distance",   want.row_distance,   got.row_distance);
            compare("col_link_valid", want.col_link_valid, got.col_link_valid);
            compare("col_link_row",   want.col_link_row,   got.col_link_row);
            compare("col_distance",   want.col_distance,   got.col_distance);
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_pixel;
    logic                          m_valid;
    logic                          m_ready;
    logic [mjge_pkg::COORD_W-1:0]  m_node_col;
    logic [mjge_pkg::COORD_W-1:0]  m_node_row;
    logic                          m_is_head;
    logic                          m_row_link_valid;
    logic [mjge_pkg::COORD_W-1:0]  m_row_link_col;
    logic [mjge_pkg::COORD_W-1:0]  m_row_distance;
    logic                          m_col_link_valid;
    logic [mjge_pkg::COORD_W-1:0]  m_col_link_row;
    logic [mjge_pkg::COORD_W-1:0]  m_col_distance;

    junction_tracker tracker = new();

    int unsigned send_gap_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_pending  = 1'b0;
    int unsigned quiet_cycles  = 0;
    int unsigned pixels_in     = 0;
    int unsigned input_stalls  = 0;

    maze_junction_graph_extract_core #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_node_col       (m_node_col),
        .m_node_row       (m_node_row),
        .m_is_head        (m_is_head),
        .m_row_link_valid (m_row_link_valid),
        .m_row_link_col   (m_row_link_col),
        .m_row_distance   (m_row_distance),
        .m_col_link_valid (m_col_link_valid),
        .m_col_link_row   (m_col_link_row),
        .m_col_distance   (m_col_distance)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit roll(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // monitor: pixel and node transactions, register writes, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.take_pixel(s_pixel);
                pixels_in++;
            end
            if (s_valid && !s_ready) input_stalls++;
            if (m_valid && m_ready)
                tracker.check_node(mjge_pkg::mjge_result_t'{m_node_col, m_node_row,
                    m_is_head, m_row_link_valid, m_row_link_col, m_row_distance,
                    m_col_link_valid, m_col_link_row, m_col_distance});
            if (psel && penable && pwrite && pready &&
                paddr[2] == mjge_pkg::REG_IMAGE_WIDTH)
                tracker.set_width(pwdata[mjge_pkg::IMG_W_W-1:0]);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // node receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= !roll(recv_stall_pct);
            end
        end
    end

    // offer one pixel, entered and left at a falling edge
    task automatic send_pixel(input bit px);
        while (roll(send_gap_pct)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_all(input bit pix[$]);
        foreach (pix[i]) send_pixel(pix[i]);
        s_valid <= 1'b0;
    endtask

    // register write then read-back, entered at a falling edge
    task automatic set_image_width(input bit [mjge_pkg::IMG_W_W-1:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mjge_pkg::REG_IMAGE_WIDTH, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_F800) | value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[mjge_pkg::IMG_W_W-1:0] !== value) begin
            $error("image_width mismatch: expected %0d, got %0d", value,
                   readback[mjge_pkg::IMG_W_W-1:0]);
            tracker.errors++;
        end
    endtask

    // all node transactions in, then let the pipeline settle
    task automatic wait_idle();
        while (tracker.pending_nodes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // rows alternate corridors and mostly-wall rows, some rows pure noise;
    // an all-wall row closes the image
    task automatic build_maze(input int unsigned w, input int unsigned h, output bit pix[$]);
        int unsigned r;
        int unsigned c;
        bit          noise;
        pix = {};
        for (r = 0; r < h; r++) begin
            noise = roll(25);
            for (c = 0; c < w; c++) begin
                if (noise)
                    pix.insert(pix.size(), 1'($urandom_range(1)));
                else if (r % 2 == 0)
                    pix.insert(pix.size(), roll(85));
                else
                    pix.insert(pix.size(), roll(30));
            end
        end
        for (c = 0; c < w; c++) pix.insert(pix.size(), 1'b0);
    endtask

    initial begin
        bit           pix [$];
        bit [10:0]    wval;
        int unsigned  phase;
        int unsigned  pick;
        int unsigned  uw;
        int unsigned  maze_pixels;

        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        s_valid = 1'b0;
        s_pixel = 1'b0;
        maze_pixels = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: corners, tee, dead ends, a full cross, wall cuts on links
        set_image_width(11'd4);
        send_all('{1, 1, 1, 1,
                   1, 0, 1, 0,
                   1, 1, 1, 1,
                   0, 1, 1, 1,
                   0, 0, 0, 0});
        wait_idle();
        // directed: zero width acts as a single column
        set_image_width(11'd0);
        send_all('{1, 0, 1, 1, 0});
        wait_idle();

        phase = 0;
        while (phase < 12 || maze_pixels < 1100) begin
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 63; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 63; end
                default: begin send_gap_pct = 10; recv_stall_pct = 10; end
            endcase

            if (phase == 3) begin
                // node output held off while pixels keep coming
                send_gap_pct   = 0;
                recv_stall_pct = 0;
                set_image_width(11'd6);
                build_maze(6, 60, pix);
                @(posedge aclk);
                hold_pending = 1'b1;
                @(negedge aclk);
            end else begin
                // one phase always takes the out-of-range width
                pick = (phase == 6) ? 0 : $urandom_range(99);
                if (pick < 3) begin
                    // wide setting cut short, so the next width lands mid-row
                    wval = 11'($urandom_range(1025, 2047));
                    set_image_width(wval);
                    pix = {};
                    repeat (30) pix.insert(pix.size(), 1'($urandom_range(1)));
                end else begin
                    if (pick < 12)
                        wval = 11'($urandom_range(0, 2));
                    else if (pick < 27)
                        wval = 11'($urandom_range(13, 40));
                    else
                        wval = 11'($urandom_range(3, 12));
                    uw = (wval == 0) ? 1 : wval;
                    set_image_width(wval);
                    build_maze(uw, $urandom_range(2, 8), pix);
                    // broken image: stops anywhere, no closing wall row
                    if (roll(15)) pix = pix[0:$urandom_range(pix.size() - 1)];
                end
            end
            maze_pixels += pix.size();

            send_all(pix);
            wait_idle();
            phase++;
        end

        $display("checked %0d node transactions from %0d pixels over %0d phases",
                 tracker.nodes_checked, pixels_in, phase + 2);
        $display("widths 0 to 2047 with mid-row changes, long output hold-off, %0d input stalls",
                 input_stalls);
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
